[hdl/ljse_pkg.sv]
`default_nettype none

package ljse_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_W         = 32;
    localparam int WIDE_W        = 128;
    localparam int RES_W         = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int K_W           = 7;

    localparam logic [K_W-1:0] K_FORCE    = K_W'(6);
    localparam logic [K_W-1:0] K_STIFF_HI = K_W'(78);
    localparam logic [K_W-1:0] K_STIFF_LO = K_W'(42);

    localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {(RES_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LJ_SCALE     = CFG_IDX_W'(0),
        CFG_LENGTH_SCALE = CFG_IDX_W'(1)
    } t_cfg_idx;

    typedef struct packed {
        logic              big;
        logic [WIDE_W-1:0] m;
    } t_wide;

    typedef struct packed {
        logic v;
        logic z;
    } t_ctl;

endpackage

`default_nettype wire

[hdl/lennard_jones_spring_eval.sv]
// Throughput: one length per cycle; the pipeline freezes while a result waits.
// Pipeline depth is set by three bit-serial divider chains in series (64 + 128 + 128 stages),
// six levels of 4-stage 128-bit multipliers and five single register stages.
// Reset: synchronous, active low; clears valid bits, scales go to 1.0.
`default_nettype none

module lennard_jones_spring_eval import ljse_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DIV_W-1:0]      i_length,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [RES_W-1:0]    o_energy,
    output logic signed [RES_W-1:0]    o_force_res,
    output logic signed [RES_W-1:0]    o_stiffness,
    output logic                       o_zero_length,
    output logic                       o_saturated,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [DIV_W-1:0]      i_cfg_data
);

    localparam int M    = 4;
    localparam int DR   = 2 * DIV_W;
    localparam int DA   = WIDE_W;
    localparam int NMUL = 11;
    localparam int LAT  = DR + 5 * M + 2 + M + 1 + DA + 1 + DA + 1;
    localparam int OW   = RES_W + 1;
    localparam int T2W  = 2 + 2 * OW;

    typedef struct packed {
        logic  neg;
        t_wide w;
    } t_swide;

    function automatic t_wide f_mulk(input t_wide x, input logic [K_W-1:0] k);
        logic [WIDE_W+K_W-1:0] p;
        t_wide                 z;
        p     = (WIDE_W+K_W)'(x.m) * (WIDE_W+K_W)'(k);
        z.big = x.big | (|p[WIDE_W+K_W-1:WIDE_W]);
        z.m   = p[WIDE_W-1:0];
        return z;
    endfunction

    function automatic t_wide f_half(input t_wide x);
        t_wide z;
        z.big = x.big;
        z.m   = {1'b0, x.m[WIDE_W-1:1]};
        return z;
    endfunction

    function automatic t_swide f_diff(input t_wide dom, input t_wide oth, input logic dom_neg);
        t_swide z;
        z.w.big = dom.big | oth.big;
        if (z.w.big || dom.m >= oth.m) begin
            z.neg = dom_neg;
            z.w.m = dom.m - oth.m;
        end else begin
            z.neg = !dom_neg;
            z.w.m = oth.m - dom.m;
        end
        return z;
    endfunction

    function automatic t_wide f_shl(input t_wide x);
        t_wide z;
        z.big = x.big | (|x.m[WIDE_W-1 -: FRAC_BITS]);
        z.m   = x.m << FRAC_BITS;
        return z;
    endfunction

    function automatic logic [OW-1:0] f_out(input t_wide x, input logic neg);
        logic             fits;
        logic [RES_W-1:0] v;
        logic [OW-1:0]    z;
        fits = !x.big && (x.m[WIDE_W-1:RES_W] == '0);
        v    = x.m[RES_W-1:0];
        if (!neg) begin
            if (!fits || v[RES_W-1]) begin
                z = {1'b1, SAT_POS};
            end else begin
                z = {1'b0, v};
            end
        end else begin
            if (!fits || v > SAT_NEG) begin
                z = {1'b1, SAT_NEG};
            end else begin
                z = {1'b0, RES_W'(-v)};
            end
        end
        return z;
    endfunction

    logic [DIV_W-1:0] r_lj_scale;
    logic [DIV_W-1:0] r_length_scale;
    logic             w_adv;
    t_ctl             r_ctl [LAT];

    assign w_adv       = !r_ctl[LAT-1].v || i_ready;
    assign o_ready     = w_adv;
    assign o_valid     = r_ctl[LAT-1].v;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lj_scale     <= DIV_W'(1) << FRAC_BITS;
            r_length_scale <= DIV_W'(1) << FRAC_BITS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LJ_SCALE:     r_lj_scale     <= i_cfg_data;
                CFG_LENGTH_SCALE: r_length_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_ctl[k] <= '0;
        end else if (w_adv) begin
            r_ctl[0] <= '{v: i_valid, z: (i_length == '0)};
            for (int k = 1; k < LAT; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    logic [DR-1:0] w_r_quo;
    logic          w_r_tag;
    t_wide         w_r;

    ljse_div #(.W(DR), .TW(1)) u_div_r (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_word ({r_length_scale, DIV_W'(0)}),
        .i_div  (i_length),
        .i_tag  (i_length == '0),
        .o_quo  (w_r_quo),
        .o_tag  (w_r_tag)
    );

    assign w_r = '{big: 1'b0, m: WIDE_W'(w_r_quo)};

    t_wide m_x [NMUL];
    t_wide m_y [NMUL];
    t_wide m_z [NMUL];

    for (genvar s = 0; s < NMUL; s++) begin : g_mul
        logic [2*DIV_W-1:0]  r_pp  [16];
        logic [6*DIV_W-1:0]  w_row [4];
        logic [6*DIV_W-1:0]  r_row [4];
        logic [8*DIV_W-1:0]  r_pq  [2];
        logic [8*DIV_W-1:0]  w_full;
        logic [2:0]          r_bg;
        t_wide               r_z;

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                w_row[i] = '0;
                for (int j = 0; j < 4; j++) begin
                    w_row[i] = w_row[i] + ((6*DIV_W)'(r_pp[4*i+j]) << (DIV_W * j));
                end
            end
        end

        assign w_full = r_pq[0] + r_pq[1];

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int i = 0; i < 4; i++) begin
                    for (int j = 0; j < 4; j++) begin
                        r_pp[4*i+j] <= m_x[s].m[DIV_W*i +: DIV_W] * m_y[s].m[DIV_W*j +: DIV_W];
                    end
                    r_row[i] <= w_row[i];
                end
                r_bg     <= {r_bg[1:0], m_x[s].big | m_y[s].big};
                r_pq[0]  <= {(2*DIV_W)'(0), r_row[0]}
                          + {DIV_W'(0), r_row[1], DIV_W'(0)};
                r_pq[1]  <= {r_row[2], (2*DIV_W)'(0)}
                          + {r_row[3][5*DIV_W-1:0], (3*DIV_W)'(0)};
                r_z.big  <= r_bg[2] | (|w_full[8*DIV_W-1:5*DIV_W]);
                r_z.m    <= w_full[5*DIV_W-1:DIV_W];
            end
        end

        assign m_z[s] = r_z;
    end

    t_wide r_rdl   [4*M];
    t_wide r_p2dl  [3*M];
    t_wide r_p4dl  [M];
    t_wide r_p6dl  [2*M];
    t_wide r_p8dl  [2*M];
    t_wide r_p12dl [M];
    t_wide r_p7dl  [M];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rdl[0]   <= w_r;
            r_p2dl[0]  <= m_z[0];
            r_p4dl[0]  <= m_z[1];
            r_p6dl[0]  <= m_z[2];
            r_p8dl[0]  <= m_z[3];
            r_p7dl[0]  <= m_z[4];
            r_p12dl[0] <= m_z[5];
            for (int k = 1; k < 4*M; k++) r_rdl[k] <= r_rdl[k-1];
            for (int k = 1; k < 3*M; k++) r_p2dl[k] <= r_p2dl[k-1];
            for (int k = 1; k < 2*M; k++) begin
                r_p6dl[k] <= r_p6dl[k-1];
                r_p8dl[k] <= r_p8dl[k-1];
            end
            for (int k = 1; k < M; k++) begin
                r_p4dl[k]  <= r_p4dl[k-1];
                r_p12dl[k] <= r_p12dl[k-1];
                r_p7dl[k]  <= r_p7dl[k-1];
            end
        end
    end

    t_wide      r_e_dom, r_e_oth, r_f_dom, r_f_oth, r_s_dom, r_s_oth;
    t_swide     r_e_d, r_f_d, r_s_d;
    logic [2:0] r_ngdl [M];
    t_wide      w_cq;

    assign w_cq = '{big: 1'b0, m: WIDE_W'(r_lj_scale) << (DIV_W - FRAC_BITS)};

    always_comb begin
        m_x[0]  = w_r;            m_y[0]  = w_r;
        m_x[1]  = m_z[0];         m_y[1]  = m_z[0];
        m_x[2]  = m_z[1];         m_y[2]  = r_p2dl[M-1];
        m_x[3]  = m_z[1];         m_y[3]  = m_z[1];
        m_x[4]  = m_z[2];         m_y[4]  = r_rdl[3*M-1];
        m_x[5]  = m_z[3];         m_y[5]  = r_p4dl[M-1];
        m_x[6]  = m_z[5];         m_y[6]  = r_rdl[4*M-1];
        m_x[7]  = m_z[5];         m_y[7]  = r_p2dl[3*M-1];
        m_x[8]  = r_e_d.w;        m_y[8]  = w_cq;
        m_x[9]  = r_f_d.w;        m_y[9]  = w_cq;
        m_x[10] = r_s_d.w;        m_y[10] = w_cq;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_dom   <= f_half(r_p12dl[M-1]);
            r_e_oth   <= r_p6dl[2*M-1];
            r_f_dom   <= m_z[6];
            r_f_oth   <= r_p7dl[M-1];
            r_s_dom   <= f_mulk(m_z[7], K_STIFF_HI);
            r_s_oth   <= f_mulk(r_p8dl[2*M-1], K_STIFF_LO);
            r_e_d     <= f_diff(r_e_dom, r_e_oth, 1'b0);
            r_f_d     <= f_diff(r_f_dom, r_f_oth, 1'b1);
            r_s_d     <= f_diff(r_s_dom, r_s_oth, 1'b0);
            r_ngdl[0] <= {r_s_d.neg, r_f_d.neg, r_e_d.neg};
            for (int k = 1; k < M; k++) r_ngdl[k] <= r_ngdl[k-1];
        end
    end

    logic [OW-1:0] r_e_out;
    t_wide         r_fx, r_sx;
    logic          r_f_neg, r_s_neg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_out <= f_out(m_z[8], r_ngdl[M-1][0]);
            r_fx    <= f_shl(f_mulk(m_z[9], K_FORCE));
            r_f_neg <= r_ngdl[M-1][1];
            r_sx    <= f_shl(m_z[10]);
            r_s_neg <= r_ngdl[M-1][2];
        end
    end

    logic [WIDE_W-1:0] w_fq, w_s1q, w_s2q;
    logic [OW+1:0]     w_ft;
    logic [1:0]        w_s1t;
    logic [T2W-1:0]    w_s2t;

    ljse_div #(.W(DA), .TW(OW + 2)) u_div_f (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_word (r_fx.m),
        .i_div  (r_length_scale),
        .i_tag  ({r_f_neg, r_fx.big, r_e_out}),
        .o_quo  (w_fq),
        .o_tag  (w_ft)
    );

    ljse_div #(.W(DA), .TW(2)) u_div_s1 (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_word (r_sx.m),
        .i_div  (r_length_scale),
        .i_tag  ({r_s_neg, r_sx.big}),
        .o_quo  (w_s1q),
        .o_tag  (w_s1t)
    );

    logic [OW-1:0] r_f_out, r_e_out2;
    t_wide         r_sx2;
    logic          r_s2_neg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_out  <= f_out('{big: w_ft[OW], m: w_fq}, w_ft[OW+1]);
            r_e_out2 <= w_ft[OW-1:0];
            r_sx2    <= f_shl('{big: w_s1t[0], m: w_s1q});
            r_s2_neg <= w_s1t[1];
        end
    end

    ljse_div #(.W(DA), .TW(T2W)) u_div_s2 (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_word (r_sx2.m),
        .i_div  (r_length_scale),
        .i_tag  ({r_s2_neg, r_sx2.big, r_f_out, r_e_out2}),
        .o_quo  (w_s2q),
        .o_tag  (w_s2t)
    );

    logic [OW-1:0] w_s_out, w_f_fin, w_e_fin;
    logic          w_cfg_zero;

    assign w_s_out    = f_out('{big: w_s2t[T2W-2], m: w_s2q}, w_s2t[T2W-1]);
    assign w_f_fin    = w_s2t[2*OW-1:OW];
    assign w_e_fin    = w_s2t[OW-1:0];
    assign w_cfg_zero = (r_lj_scale == '0) || (r_length_scale == '0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_ctl[LAT-2].z || w_cfg_zero) begin
                o_energy    <= '0;
                o_force_res <= '0;
                o_stiffness <= '0;
                o_saturated <= 1'b0;
            end else begin
                o_energy    <= w_e_fin[RES_W-1:0];
                o_force_res <= w_f_fin[RES_W-1:0];
                o_stiffness <= w_s_out[RES_W-1:0];
                o_saturated <= w_e_fin[RES_W] | w_f_fin[RES_W] | w_s_out[RES_W];
            end
            o_zero_length <= r_ctl[LAT-2].z;
        end
    end

    a_zero_tag_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[DR-1].v |-> (w_r_tag == r_ctl[DR-1].z))
        else $error("zero flag out of step with divider");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length |->
            o_energy == '0 && o_force_res == '0 && o_stiffness == '0 && !o_saturated)
        else $error("zero length with nonzero result");

    a_sat_on_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_energy == SAT_POS || o_energy == SAT_NEG ||
            o_force_res == SAT_POS || o_force_res == SAT_NEG ||
            o_stiffness == SAT_POS || o_stiffness == SAT_NEG)
        else $error("saturated flag without a clipped result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_ctl[0]))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[hdl/ljse_div.sv]
`default_nettype none

module ljse_div import ljse_pkg::*; #(
    parameter int W  = WIDE_W,
    parameter int TW = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [W-1:0]     i_word,
    input  wire logic [DIV_W-1:0] i_div,
    input  wire logic [TW-1:0]    i_tag,
    output logic      [W-1:0]     o_quo,
    output logic      [TW-1:0]    o_tag
);

    logic [DIV_W-1:0] r_rem [W];
    logic [W-1:0]     r_wd  [W];
    logic [DIV_W-1:0] r_dv  [W];
    logic [TW-1:0]    r_tg  [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [DIV_W-1:0] w_rem_in;
        logic [DIV_W-1:0] w_dv_in;
        logic [W-1:0]     w_wd_in;
        logic [TW-1:0]    w_tg_in;
        logic [DIV_W:0]   w_t;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_dv_in  = i_div;
            assign w_wd_in  = i_word;
            assign w_tg_in  = i_tag;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_dv_in  = r_dv[k-1];
            assign w_wd_in  = r_wd[k-1];
            assign w_tg_in  = r_tg[k-1];
        end

        assign w_t  = {w_rem_in, w_wd_in[W-1]};
        assign w_ge = (w_t >= {1'b0, w_dv_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? DIV_W'(w_t - {1'b0, w_dv_in}) : w_t[DIV_W-1:0];
                r_wd[k]  <= {w_wd_in[W-2:0], w_ge};
                r_dv[k]  <= w_dv_in;
                r_tg[k]  <= w_tg_in;
            end
        end
    end

    assign o_quo = r_wd[W-1];
    assign o_tag = r_tg[W-1];

endmodule

`default_nettype wire

[verif/lennard_jones_spring_eval_checker.sv]
`default_nettype none

module lennard_jones_spring_eval_checker import ljse_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_ready_in,
    input  wire logic [DIV_W-1:0]     i_length,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [RES_W-1:0]     i_energy,
    input  wire logic [RES_W-1:0]     i_force_res,
    input  wire logic [RES_W-1:0]     i_stiffness,
    input  wire logic                 i_zero_length,
    input  wire logic                 i_saturated,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIV_W-1:0]     i_cfg_data,
    output int                        o_fails,
    output int                        o_pending
);

    typedef struct {
        bit           huge;
        bit [127:0]   mag;
    } mag_t;

    typedef struct {
        bit [63:0] energy;
        bit [63:0] force_res;
        bit [63:0] stiffness;
        bit        zero_length;
        bit        saturated;
    } spring_res_t;

    bit [31:0]   lj_c;
    bit [31:0]   len_a;
    spring_res_t spring_q[$];

    function automatic mag_t mk(bit [63:0] v);
        mag_t x;
        x.huge = 0;
        x.mag  = {64'b0, v};
        return x;
    endfunction

    function automatic mag_t saturate_mag();
        mag_t x;
        x.huge = 1;
        x.mag  = '1;
        return x;
    endfunction

    function automatic mag_t mul_q32(mag_t x, mag_t y);
        bit [255:0] p;
        mag_t z;
        p = {128'b0, x.mag} * {128'b0, y.mag};
        z.mag  = p[159:32];
        z.huge = x.huge | y.huge;
        if (|p[255:160]) z = saturate_mag();
        return z;
    endfunction

    function automatic mag_t shift_up(mag_t x, int n);
        if (n == 0) return x;
        if ((x.mag >> (128 - n)) != 0) return saturate_mag();
        x.mag = x.mag << n;
        return x;
    endfunction

    function automatic mag_t div_by_a(mag_t x, bit [31:0] a);
        x = shift_up(x, FRAC_BITS_DEF);
        if (!x.huge) x.mag = x.mag / {96'b0, a};
        return x;
    endfunction

    function automatic mag_t abs_diff(mag_t dom, mag_t oth, bit dom_neg, output bit neg);
        mag_t z;
        if (dom.huge || oth.huge) begin
            neg = dom_neg;
            dom.huge = 1;
            return dom;
        end
        z.huge = 0;
        if (dom.mag >= oth.mag) begin
            neg   = dom_neg;
            z.mag = dom.mag - oth.mag;
        end else begin
            neg   = !dom_neg;
            z.mag = oth.mag - dom.mag;
        end
        return z;
    endfunction

    function automatic bit [63:0] clip(mag_t m, bit neg, inout bit sat);
        bit fits;
        bit [63:0] v;
        fits = !m.huge && m.mag[127:64] == 0;
        v = m.mag[63:0];
        if (!neg) begin
            if (!fits || v > 64'h7FFF_FFFF_FFFF_FFFF) begin
                sat = 1;
                return SAT_POS;
            end
            return v;
        end
        if (!fits || v > 64'h8000_0000_0000_0000) begin
            sat = 1;
            return SAT_NEG;
        end
        return 64'd0 - v;
    endfunction

    function automatic spring_res_t lj_eval(bit [31:0] len, bit [31:0] c, bit [31:0] a);
        spring_res_t res;
        mag_t r, p2, p4, p6, p7, p8, p12, p13, p14, cq, e, f, s, hi;
        bit neg, sat;
        res = '{default: 0};
        sat = 0;
        if (len == 0) begin
            res.zero_length = 1;
            return res;
        end
        if (c == 0 || a == 0) return res;
        r   = mk({a, 32'b0} / {32'b0, len});
        p2  = mul_q32(r, r);
        p4  = mul_q32(p2, p2);
        p6  = mul_q32(p4, p2);
        p7  = mul_q32(p6, r);
        p8  = mul_q32(p4, p4);
        p12 = mul_q32(p8, p4);
        p13 = mul_q32(p12, r);
        p14 = mul_q32(p12, p2);
        cq  = shift_up(mk({32'b0, c}), 32 - FRAC_BITS_DEF);
        hi = p12;
        hi.mag = hi.mag >> 1;
        e = abs_diff(hi, p6, 1'b0, neg);
        e = mul_q32(e, cq);
        res.energy = clip(e, neg, sat);
        f = abs_diff(p13, p7, 1'b1, neg);
        f = mul_q32(f, cq);
        f = mul_q32(f, mk(64'(K_FORCE) << 32));
        f = div_by_a(f, a);
        res.force_res = clip(f, neg, sat);
        s = abs_diff(mul_q32(p14, mk(64'(K_STIFF_HI) << 32)),
                     mul_q32(p8, mk(64'(K_STIFF_LO) << 32)), 1'b0, neg);
        s = mul_q32(s, cq);
        s = div_by_a(div_by_a(s, a), a);
        res.stiffness = clip(s, neg, sat);
        res.saturated = sat;
        return res;
    endfunction

    assign o_pending = spring_q.size();

    always @(posedge i_clk) begin
        spring_res_t want;
        if (!i_rst_n) begin
            lj_c  <= 32'h1 << FRAC_BITS_DEF;
            len_a <= 32'h1 << FRAC_BITS_DEF;
            spring_q.delete();
            o_fails <= 0;
        end else begin
            if (i_valid && i_ready_in) spring_q.push_back(lj_eval(i_length, lj_c, len_a));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_LJ_SCALE) lj_c <= i_cfg_data;
                else if (i_cfg_index == CFG_LENGTH_SCALE) len_a <= i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (spring_q.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fails <= o_fails + 1;
                end else begin
                    want = spring_q.pop_front();
                    if (want.energy != i_energy || want.force_res != i_force_res ||
                        want.stiffness != i_stiffness ||
                        want.zero_length != i_zero_length ||
                        want.saturated != i_saturated) o_fails <= o_fails + 1;
                    if (want.energy != i_energy)
                        $error("energy exp %h got %h", want.energy, i_energy);
                    if (want.force_res != i_force_res)
                        $error("force_res exp %h got %h", want.force_res, i_force_res);
                    if (want.stiffness != i_stiffness)
                        $error("stiffness exp %h got %h", want.stiffness, i_stiffness);
                    if (want.zero_length != i_zero_length)
                        $error("zero_length exp %0d got %0d", want.zero_length,
                               i_zero_length);
                    if (want.saturated != i_saturated)
                        $error("saturated exp %0d got %0d", want.saturated, i_saturated);
                end
            end
        end
    end

endmodule

`default_nettype wire

[verif/lennard_jones_spring_eval_test.sv]
`default_nettype none

module lennard_jones_spring_eval_test import ljse_pkg::*;;

    localparam int LIMIT = 600000;
    localparam int LATENCY = 349;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = CFG_IDX_W'(3);

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic [DIV_W-1:0] i_length, i_cfg_data;
    logic signed [RES_W-1:0] o_energy, o_force_res, o_stiffness;
    logic o_zero_length, o_saturated, i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    int fails, pending, cycles, sent;
    int send_idle, recv_idle;
    bit [31:0] cur_a;

    lennard_jones_spring_eval u_top (.*);

    lennard_jones_spring_eval_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_length(i_length), .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_energy(o_energy), .i_force_res(o_force_res), .i_stiffness(o_stiffness),
        .i_zero_length(o_zero_length), .i_saturated(o_saturated),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fails(fails), .o_pending(pending)
    );

    initial i_clk = 0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) i_ready <= $urandom_range(0, 99) >= recv_idle;

    task automatic set_idle();
        if (sent < 320) begin
            send_idle = 32;
            recv_idle = 48;
        end else if (sent < 640) begin
            send_idle = 48;
            recv_idle = 32;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic send(bit [31:0] len);
        set_idle();
        while ($urandom_range(0, 99) < send_idle) @(negedge i_clk);
        i_valid  = 1;
        i_length = len;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 0;
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 0;
        if (idx == CFG_LENGTH_SCALE) cur_a = val;
    endtask

    function automatic bit [31:0] pick_len();
        bit [63:0] t;
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: begin
                t = {32'b0, cur_a} + $urandom_range(0, cur_a) - (cur_a >> 3);
                return t[31:0];
            end
            2: return $urandom_range(0, 255);
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic random_run(int n);
        repeat (n) send(pick_len());
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_length = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_LJ_SCALE;
        i_cfg_data = 0;
        cycles = 0;
        sent = 0;
        cur_a = 32'h10000;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;

        send(0); send(1); send(32'hFFFF_FFFF); send(32'h10000); send(32'h8000);
        send(32'h11F46); send(32'h20000); send(32'h1000); send(32'h8000_0000);
        send(32'hF000); send(32'h3000); send(32'h1_8000);
        random_run(140);

        write_reg(CFG_LJ_SCALE, 0);
        send(32'h10000); send(0); send(32'h8000);
        random_run(60);

        write_reg(CFG_LJ_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_LENGTH_SCALE, 1);
        send(1); send(2); send(32'hFFFF_FFFF);
        random_run(150);

        write_reg(CFG_LJ_SCALE, 1);
        write_reg(CFG_LENGTH_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_2, 32'h1234_5678);
        write_reg(CFG_UNUSED_3, 32'h0);
        send(32'hFFFF_FFFF); send(32'hFFFF_FFFE); send(1);
        random_run(150);

        repeat (3) begin
            write_reg(CFG_LJ_SCALE, $urandom());
            write_reg(CFG_LENGTH_SCALE, $urandom_range(32'h8000, 32'h30000));
            random_run(140);
        end

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 50) @(negedge i_clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
